// File: hw/rtl/pwsz_pkg.sv
// Shared constants, types and register indexes for the pixel window scale/zoom block.
package pwsz_pkg;

   localparam int MAX_ZOOM  = 8;
   localparam int MAX_SKIP  = 16;
   localparam int MAX_WIDTH = 4096;
   localparam int ADDR_BITS = 24;

   localparam int K_W     = $clog2(MAX_ZOOM + 1);
   localparam int J_W     = (MAX_ZOOM > 1) ? $clog2(MAX_ZOOM) : 1;
   localparam int SKIP_W  = $clog2(MAX_SKIP + 1);
   localparam int PHASE_W = $clog2(MAX_SKIP);
   localparam int W_W     = $clog2(MAX_WIDTH + 1);
   localparam int COL_W   = 16;

   localparam int QDEPTH = 8;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [2:0] {
      CSR_GAIN         = 3'd0,
      CSR_BIAS         = 3'd1,
      CSR_OUT_LOW      = 3'd2,
      CSR_OUT_HIGH     = 3'd3,
      CSR_CLAMP_ENABLE = 3'd4,
      CSR_ZOOM         = 3'd5,
      CSR_OUT_WIDTH    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [31:0] gain;
      logic [31:0] bias;
      logic [7:0]  out_low;
      logic [7:0]  out_high;
      logic        clamp_enable;
      logic [5:0]  zoom;
      logic [12:0] out_width;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] base;
      logic [7:0]           out_byte;
      logic [31:0]          sample;
      logic [K_W-1:0]       k;
      logic [W_W-1:0]       w;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              empty;
   } qstat_type;

endpackage

// File: hw/rtl/pixel_window_scale_zoom.sv
// Top level of the pixel window scale/zoom block: registers, front end, queue, replicator.
//
// Channel   Dir  Handshake             Payload
// req_      in   req_tvalid/tready     tdata = sample; tlast = end_of_row; tuser = end_of_slice
// rsp_      out  rsp_tvalid/tready     tdata = out_addr, out_byte, out_sample; tlast = last
// csr_      in   csr_we                csr_index selects register, csr_wdata holds value
//
// In full-size and decimation modes one word is taken every cycle while req_tready
// is high; a dropped pixel produces nothing. In magnify mode each pixel becomes a
// k by k block of writes (k up to 8), all sent through the single result register.
// First result leaves after the two scale stages, the queue and the result register.
// Reset is synchronous: registers go to their defaults, all placement state clears.
// A stalled result port fills the 8-entry queue; req_tready drops at 8 words in flight.
module pixel_window_scale_zoom
   import pwsz_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   input  logic        req_tlast,
   input  logic        req_tuser,   // [0] end_of_slice
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [23:0] out_addr, [31:24] out_byte, [63:32] out_sample
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   push_type  push;
   entry_type head;
   qstat_type qstat;
   logic      pop;

   // Register writes: keep only the low bits each register holds
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GAIN:         cfg_in.gain         = csr_wdata;
            CSR_BIAS:         cfg_in.bias         = csr_wdata;
            CSR_OUT_LOW:      cfg_in.out_low      = csr_wdata[7:0];
            CSR_OUT_HIGH:     cfg_in.out_high     = csr_wdata[7:0];
            CSR_CLAMP_ENABLE: cfg_in.clamp_enable = csr_wdata[0];
            CSR_ZOOM:         cfg_in.zoom         = csr_wdata[5:0];
            CSR_OUT_WIDTH:    cfg_in.out_width    = csr_wdata[12:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain         <= 32'd65536;
         cfg_ff.bias         <= 32'd0;
         cfg_ff.out_low      <= 8'd0;
         cfg_ff.out_high     <= 8'd255;
         cfg_ff.clamp_enable <= 1'b1;
         cfg_ff.zoom         <= 6'd1;
         cfg_ff.out_width    <= 13'd512;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pwsz_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .qstat      (qstat),
      .push       (push)
   );

   pwsz_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .stat  (qstat)
   );

   pwsz_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hw/rtl/pwsz_front.sv
// Front end: accept words, track decimation and placement state, scale the sample.
module pwsz_front
   import pwsz_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tuser,
   input  qstat_type   qstat,
   output push_type    push
);

   logic [PHASE_W-1:0]   col_phase_ff, col_phase_in;
   logic [PHASE_W-1:0]   row_phase_ff, row_phase_in;
   logic [ADDR_BITS-1:0] write_addr_ff, write_addr_in;
   logic [ADDR_BITS-1:0] row_base_ff, row_base_in;
   logic [COL_W-1:0]     col_offset_ff, col_offset_in;

   logic                 s1_valid_ff, s1_valid_in;
   logic [63:0]          s1_prod_ff, s1_prod_in;
   logic [ADDR_BITS-1:0] s1_base_ff, s1_base_in;
   logic [31:0]          s1_sample_ff;
   logic [K_W-1:0]       s1_k_ff, s1_k_in;
   logic [W_W-1:0]       s1_w_ff;

   logic                 s2_valid_ff;
   logic [63:0]          s2_t_ff, s2_t_in;
   logic [ADDR_BITS-1:0] s2_base_ff;
   logic [31:0]          s2_sample_ff;
   logic [K_W-1:0]       s2_k_ff;
   logic [W_W-1:0]       s2_w_ff;

   logic                 accept, mode_full, mode_dec, keep;
   logic [QCNT_W:0]      in_flight;
   logic [SKIP_W-1:0]    skip, col_inc, row_inc;
   logic [PHASE_W-1:0]   col_next, row_next;
   logic [5:0]           zoom_neg;
   logic [K_W-1:0]       kmag;
   logic [W_W-1:0]       wsat;
   logic [K_W+W_W-1:0]   row_step;
   logic signed [63:0]   prod;
   logic [31:0]          q, c1;
   logic [7:0]           byte_val;

   // Credit: queue entries plus words in the two scale stages
   assign in_flight  = (QCNT_W+1)'(qstat.count) + (QCNT_W+1)'(s1_valid_ff)
                     + (QCNT_W+1)'(s2_valid_ff);
   assign req_tready = in_flight < (QCNT_W+1)'(QDEPTH);
   assign accept     = req_tvalid && req_tready;

   assign mode_full = ($signed(cfg.zoom) >= -6'sd1) && ($signed(cfg.zoom) <= 6'sd1);
   assign mode_dec  = $signed(cfg.zoom) > 6'sd1;

   assign skip = (int'(cfg.zoom[4:0]) > MAX_SKIP) ? SKIP_W'(MAX_SKIP)
                                                  : SKIP_W'(cfg.zoom[4:0]);
   assign zoom_neg = 6'(-cfg.zoom);
   assign kmag = (int'(zoom_neg) > MAX_ZOOM) ? K_W'(MAX_ZOOM) : K_W'(zoom_neg);
   assign wsat = (int'(cfg.out_width) > MAX_WIDTH) ? W_W'(MAX_WIDTH)
                                                   : W_W'(cfg.out_width);
   assign row_step = (K_W+W_W)'(kmag) * (K_W+W_W)'(wsat);

   assign keep     = (col_phase_ff == '0) && (row_phase_ff == '0);
   assign col_inc  = SKIP_W'(col_phase_ff) + SKIP_W'(1);
   assign row_inc  = SKIP_W'(row_phase_ff) + SKIP_W'(1);
   assign col_next = (col_inc >= skip) ? '0 : PHASE_W'(col_inc);
   assign row_next = (row_inc >= skip) ? '0 : PHASE_W'(row_inc);

   assign prod = $signed(req_tdata) * $signed(cfg.gain);

   always_comb begin
      col_phase_in  = col_phase_ff;
      row_phase_in  = row_phase_ff;
      write_addr_in = write_addr_ff;
      row_base_in   = row_base_ff;
      col_offset_in = col_offset_ff;
      s1_valid_in   = 1'b0;
      s1_base_in    = write_addr_ff;
      s1_k_in       = K_W'(1);
      s1_prod_in    = prod;
      if (accept) begin
         if (mode_full) begin
            s1_valid_in   = 1'b1;
            write_addr_in = write_addr_ff + ADDR_BITS'(1);
         end else if (mode_dec) begin
            s1_valid_in  = keep;
            if (keep) begin
               write_addr_in = write_addr_ff + ADDR_BITS'(1);
            end
            col_phase_in = col_next;
            if (req_tlast) begin
               col_phase_in = '0;
               row_phase_in = req_tuser ? '0 : row_next;
            end
         end else begin
            s1_valid_in = 1'b1;
            s1_base_in  = row_base_ff + ADDR_BITS'(col_offset_ff);
            s1_k_in     = kmag;
            if (req_tlast) begin
               col_offset_in = '0;
               row_base_in   = row_base_ff + ADDR_BITS'(row_step);
            end else begin
               col_offset_in = col_offset_ff + COL_W'(kmag);
            end
         end
      end
   end

   // Add the bias, shifted left by 16 bits, to the product
   assign s2_t_in = s1_prod_ff + {{16{cfg.bias[31]}}, cfg.bias, 16'b0};

   // Truncate toward zero, then clamp or keep the low byte
   always_comb begin
      q  = s2_t_ff[63:32] + 32'(s2_t_ff[63] && (s2_t_ff[31:0] != '0));
      c1 = ($signed(q) < $signed({24'b0, cfg.out_low})) ? {24'b0, cfg.out_low} : q;
      if (!cfg.clamp_enable) begin
         byte_val = q[7:0];
      end else if ($signed(c1) > $signed({24'b0, cfg.out_high})) begin
         byte_val = cfg.out_high;
      end else begin
         byte_val = c1[7:0];
      end
   end

   assign push.valid          = s2_valid_ff;
   assign push.entry.base     = s2_base_ff;
   assign push.entry.out_byte = byte_val;
   assign push.entry.sample   = s2_sample_ff;
   assign push.entry.k        = s2_k_ff;
   assign push.entry.w        = s2_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_phase_ff  <= '0;
         row_phase_ff  <= '0;
         write_addr_ff <= '0;
         row_base_ff   <= '0;
         col_offset_ff <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
      end else begin
         col_phase_ff  <= col_phase_in;
         row_phase_ff  <= row_phase_in;
         write_addr_ff <= write_addr_in;
         row_base_ff   <= row_base_in;
         col_offset_ff <= col_offset_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_prod_ff   <= s1_prod_in;
      s1_base_ff   <= s1_base_in;
      s1_sample_ff <= req_tdata;
      s1_k_ff      <= s1_k_in;
      s1_w_ff      <= wsat;
      s2_t_ff      <= s2_t_in;
      s2_base_ff   <= s1_base_ff;
      s2_sample_ff <= s1_sample_ff;
      s2_k_ff      <= s1_k_ff;
      s2_w_ff      <= s1_w_ff;
   end

endmodule

// File: hw/rtl/pwsz_queue.sv
// Short queue of scaled pixels between the front end and the replicator.
module pwsz_queue
   import pwsz_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  logic      pop,
   output entry_type head,
   output qstat_type stat
);

   entry_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push.valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// File: hw/rtl/pwsz_back.sv
// Back end: expand each queued pixel into its block of writes and drive the result register.
module pwsz_back
   import pwsz_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  entry_type   head,
   input  qstat_type   qstat,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast
);

   logic [J_W-1:0]       j_ff, j_in;
   logic [J_W-1:0]       m_ff, m_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [ADDR_BITS-1:0] line_ff, line_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          rsp_data_ff;
   logic                 rsp_last_ff;

   logic                 first, m_last, j_last, emit;
   logic [J_W-1:0]       k_top;
   logic [ADDR_BITS-1:0] cur_addr, row_start;

   assign first     = (j_ff == '0) && (m_ff == '0);
   assign cur_addr  = first ? head.base : addr_ff;
   assign row_start = first ? head.base : line_ff;
   assign k_top     = J_W'(head.k - K_W'(1));
   assign m_last    = (m_ff == k_top);
   assign j_last    = (j_ff == k_top);
   assign emit      = !qstat.empty && (!rsp_valid_ff || rsp_tready);
   assign pop       = emit && m_last && j_last;

   always_comb begin
      j_in    = j_ff;
      m_in    = m_ff;
      addr_in = addr_ff;
      line_in = line_ff;
      if (emit) begin
         if (m_last) begin
            // advance to the next replicated column
            m_in    = '0;
            j_in    = j_last ? '0 : j_ff + J_W'(1);
            addr_in = row_start + ADDR_BITS'(1);
            line_in = row_start + ADDR_BITS'(1);
         end else begin
            m_in    = m_ff + J_W'(1);
            addr_in = cur_addr + ADDR_BITS'(head.w);
            line_in = row_start;
         end
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff         <= '0;
         m_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         j_ff         <= j_in;
         m_ff         <= m_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      line_ff <= line_in;
      if (emit) begin
         rsp_data_ff <= {head.sample, head.out_byte, cur_addr};
         rsp_last_ff <= m_last && j_last;
      end
   end

endmodule

// File: hw/rtl/pwsz_checker.sv
// Port-level checks for the pixel window scale/zoom block, bound to the top level.
module pwsz_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic        rsp_accept;
   logic        pend_ff, pend_in;
   logic [31:0] pend_sample_ff;
   logic [6:0]  run_ff, run_in;

   assign rsp_accept = rsp_tvalid && rsp_tready;

   always_comb begin
      pend_in = pend_ff;
      run_in  = run_ff;
      if (rsp_accept) begin
         pend_in = !rsp_tlast;
         run_in  = rsp_tlast ? 7'd0 : ((run_ff == 7'd127) ? run_ff : run_ff + 7'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         run_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         run_ff  <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_accept) begin
         pend_sample_ff <= rsp_tdata[63:32];
      end
   end

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // every write of one replicated block carries the same sample
   a_block_sample: assert property (@(posedge clock) disable iff (reset)
      pend_ff && rsp_accept |-> rsp_tdata[63:32] == pend_sample_ff)
      else $error("sample changed inside a replicated block");

   // a block holds at most 64 writes
   a_block_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> run_ff < 7'd64)
      else $error("replicated block longer than 64 writes");

endmodule

bind pixel_window_scale_zoom pwsz_checker u_pwsz_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
